>>> design/lcdns_pkg.sv
`timescale 1ns / 1ps

package lcdns_pkg;

  // Request kinds on the input tuser field
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_NUM  = 2'd2;
  localparam logic [1:0] KIND_INIT = 2'd3;

  localparam int unsigned PULSE_W     = 16;
  localparam int unsigned WAIT_W      = 17;
  localparam int unsigned EV_W        = 5;
  localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd250;

  // Index of the final event for each request kind
  localparam logic [EV_W-1:0] LAST_EV_BYTE = 5'd3;
  localparam logic [EV_W-1:0] LAST_EV_NUM  = 5'd11;
  localparam logic [EV_W-1:0] LAST_EV_INIT = 5'd24;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [3:0] INIT_NIB_A = 4'h3;
  localparam logic [3:0] INIT_NIB_B = 4'h2;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Decimal digits handed from the conversion unit
  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  // Command bytes sent after the four wake-up nibbles
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h28;
      2'd1: b = 8'h0D;
      2'd2: b = 8'h06;
      2'd3: b = 8'h01;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

>>> design/lcdns_digit_unit.sv
`timescale 1ns / 1ps

module lcdns_digit_unit
  import lcdns_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] value,
  output logic       done,
  output digits_t    digits
);

  logic       busy;
  logic       tens_phase;
  logic [7:0] rem;
  logic [3:0] hund_cnt;
  logic [3:0] tens_cnt;

  // Shared compare/subtract: divisor is 100 first, then 10
  logic [7:0] divisor;
  logic       fits;
  logic [7:0] diff;

  assign divisor = tens_phase ? 8'd10 : 8'd100;
  assign fits    = (rem >= divisor);
  assign diff    = rem - divisor;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      tens_phase <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        tens_phase <= 1'b0;
      end else if (busy && !fits) begin
        if (tens_phase) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          tens_phase <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient counters
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= value;
      hund_cnt <= '0;
      tens_cnt <= '0;
    end else if (busy && fits) begin
      rem <= diff;
      if (tens_phase) begin
        tens_cnt <= tens_cnt + 4'd1;
      end else begin
        hund_cnt <= hund_cnt + 4'd1;
      end
    end
  end

  assign digits.hundreds = hund_cnt;
  assign digits.tens     = tens_cnt;
  assign digits.units    = rem[3:0];

endmodule

>>> design/char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps
// A number request first runs the digit unit (repeated subtraction of 100 then 10) before
//   its pin events are emitted.
// Throughput: one pin event per cycle when not stalled; the next request is taken only
//   after the last pin event of the previous one has been emitted.
// Reset (rst, synchronous): idle, output empty, pins 0, pulse_ticks back to 250.

module char_lcd_nibble_sequencer
  import lcdns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration: pulse_ticks
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] value
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  // Pin events
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [3:0] data_nibble, [4] enable_line,
                                     // [21:5] wait_ticks, [23:22] zero
  output logic        m_axis_tuser,  // [0] select_line
  output logic        m_axis_tlast   // last
);

  state_t             state;
  logic [1:0]         kind_r;
  logic [7:0]         value_r;
  logic [EV_W-1:0]    ev;
  logic [PULSE_W-1:0] pulse_ticks;
  logic [3:0]         pin_nibble;
  logic               pin_select;

  logic               conv_start;
  logic               conv_done;
  digits_t            digits;

  logic               s_fire;
  logic               slot_free;
  logic               emit;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks <= PULSE_RESET;
    end else if (cfg_valid) begin
      pulse_ticks <= cfg_data;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign emit          = (state == ST_EMIT) && slot_free;
  assign conv_start    = s_fire && (s_axis_tuser == KIND_NUM);

  lcdns_digit_unit u_digit (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .value  (s_axis_tdata),
    .done   (conv_done),
    .digits (digits)
  );

  // Event decode for the current index
  logic [EV_W-1:0] last_ev;
  logic [EV_W-1:0] e1;
  logic [3:0]      ni;
  logic [2:0]      bi;
  logic [7:0]      cur_byte;
  logic [3:0]      digit;
  logic            ev_sel;
  logic [3:0]      ev_nib;
  logic            ev_en;
  logic            ev_extra;
  logic [WAIT_W-1:0] ev_wait;

  always_comb begin
    e1       = ev - 5'd1;
    ni       = e1[4:1];
    bi       = 3'(ni - 4'd4);
    digit    = digits.units;
    cur_byte = value_r;
    ev_sel   = pin_select;
    ev_nib   = pin_nibble;
    ev_en    = 1'b0;
    ev_extra = 1'b0;
    last_ev  = LAST_EV_BYTE;
    unique case (kind_r)
      KIND_CMD, KIND_DATA: begin
        last_ev = LAST_EV_BYTE;
        ev_sel  = kind_r[0];
        ev_nib  = ev[1] ? value_r[3:0] : value_r[7:4];
        ev_en   = !ev[0];
      end
      KIND_NUM: begin
        last_ev = LAST_EV_NUM;
        unique case (ev[3:2])
          2'd0:    digit = digits.hundreds;
          2'd1:    digit = digits.tens;
          default: digit = digits.units;
        endcase
        cur_byte = ASCII_ZERO | {4'd0, digit};
        ev_sel   = 1'b1;
        ev_nib   = ev[1] ? cur_byte[3:0] : cur_byte[7:4];
        ev_en    = !ev[0];
      end
      KIND_INIT: begin
        last_ev = LAST_EV_INIT;
        if (ev != '0) begin
          ev_sel = 1'b0;
          ev_en  = !e1[0];
          if (ni < 4'd4) begin
            // wake-up nibbles, each low phase carries the extra wait
            ev_nib   = (ni == 4'd3) ? INIT_NIB_B : INIT_NIB_A;
            ev_extra = e1[0];
          end else begin
            cur_byte = init_byte(bi[2:1]);
            ev_nib   = bi[0] ? cur_byte[3:0] : cur_byte[7:4];
            ev_extra = (ev == LAST_EV_INIT);
          end
        end
      end
      default: begin
        last_ev = LAST_EV_BYTE;
      end
    endcase
    ev_wait = {1'b0, pulse_ticks} + (ev_extra ? {1'b0, pulse_ticks} : '0);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ev         <= '0;
      pin_nibble <= '0;
      pin_select <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            ev    <= '0;
            state <= (s_axis_tuser == KIND_NUM) ? ST_CONV : ST_EMIT;
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            pin_nibble <= ev_nib;
            pin_select <= ev_sel;
            ev         <= ev + 5'd1;
            if (ev == last_ev) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      kind_r  <= s_axis_tuser;
      value_r <= s_axis_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {2'b00, ev_wait, ev_en, ev_nib};
      m_axis_tuser <= ev_sel;
      m_axis_tlast <= (ev == last_ev);
    end
  end

endmodule

>>> design/lcdns_checker.sv
`timescale 1ns / 1ps

module lcdns_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Output empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

  // One request at a time: busy after taking one
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready stayed high after a request");

  // Enable-high phase is never the final event
  a_last_low: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tlast)
    else $error("last on an enable-high event");

  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed while stalled");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (.*);
